// ===== src/fmtpx_pkg.sv =====
package fmtpx_pkg;

  // Default store depth in words (a power of two).
  localparam int unsigned STORE_DEPTH_DEF = 65536;
  // Width of y * row_pitch + x before it wraps to the store depth.
  localparam int unsigned SUM_W = 17;
  localparam int unsigned WORD_W = 32;
  // Depth of the command and result queues.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [8:0] SIDE_RESET = 9'd256;

  typedef enum logic [2:0] {
    FMT_RGBA8888 = 3'd0,
    FMT_RGBA4444 = 3'd1,
    FMT_RGB5A1   = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_A8       = 3'd4
  } pix_fmt_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FILL  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_PITCH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_REPLY = 2'd3
  } op_e;

  typedef struct packed {
    logic [2:0] fmt;
    logic [8:0] width;
    logic [8:0] height;
    logic [8:0] pitch;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              ok;
    logic [SUM_W-1:0]  base;
    logic [7:0]        col;
    logic [7:0]        row;
    logic [8:0]        col_end;
    logic [8:0]        row_end;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       ok;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } pack_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  function automatic pack_t pack_pixel(logic [2:0] fmt, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic [7:0] a);
    pack_t p;
    p.valid = 1'b1;
    p.word  = '0;
    case (fmt)
      FMT_RGBA8888: p.word = {a, b, g, r};
      FMT_RGBA4444: p.word = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
      FMT_RGB5A1:   p.word = {16'd0, r[7:3], g[7:3], b[7:3], |a};
      FMT_RGB565:   p.word = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_A8:       p.word = {24'd0, a};
      default:      p.valid = 1'b0;
    endcase
    return p;
  endfunction

  function automatic rgba_t unpack_pixel(logic [2:0] fmt, logic [WORD_W-1:0] w);
    rgba_t c;
    c = '0;
    case (fmt)
      FMT_RGBA8888: c = {w[7:0], w[15:8], w[23:16], w[31:24]};
      FMT_RGBA4444: c = {w[15:12], w[15:12], w[11:8], w[11:8],
                         w[7:4], w[7:4], w[3:0], w[3:0]};
      FMT_RGB5A1:   c = {w[15:11], 3'd0, w[10:6], 3'd0, w[5:1], 3'd0, {8{w[0]}}};
      FMT_RGB565:   c = {w[15:11], 3'd0, w[10:5], 2'd0, w[4:0], 3'd0, 8'hff};
      FMT_A8:       c = {8'hff, 8'hff, 8'hff, w[7:0]};
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/format_converting_pixel_store_top.sv =====
// Format-converting pixel store.
// Holds packed pixels (RGBA8888, RGBA4444, RGB5A1, RGB565 or A8) at word
// address y * row_pitch + x, wrapped to STORE_DEPTH (a power of two).
// Requests enter through a queue port: push an item while full is low. Each
// request gives exactly one transaction on the result port: while empty is
// low the oldest result sits on the result ports; pop takes it.
// Read: unpacks the stored pixel to RGBA8888, ok low and zeros when out of
// bounds or the format code is unknown. Write: packs and stores the colour.
// Fill: packs once and writes the rectangle clipped to the content size,
// one pixel per cycle, the last once the result queue has room; always
// answers ok high with zero colour. A read or write result is registered
// in the response stage and then written into the result queue for pop.
// Throughput: one read or write per cycle while the result queue has room,
// set by the single store port; a fill holds the back end until it has
// written every covered pixel (a fill that covers nothing only answers).
// A stalled result port fills the result queue and then the command queue;
// full then rises and holds the input until pop drains results.
// Reset empties both queues and restores the registers (format RGBA8888,
// width, height and pitch 256). The store is not cleared: no clearing pass.
// Write configuration only while the block is idle.
module format_converting_pixel_store_top
  import fmtpx_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_wdata_i,
  // request channel
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [8:0] rect_width_i,
  input  logic [8:0] rect_height_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  // result channel
  output logic       empty,
  input  logic       pop,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [7:0] alpha_out_o,
  output logic       ok_o
);

  cfg_t              cfg_q;
  cmd_t              front_cmd, back_cmd;
  logic              cmd_empty, cmd_pop;
  logic              res_push;
  res_t              back_res, out_res;
  logic [QCNT_W-1:0] out_cnt, out_free;

  // Configuration registers; any index of the 2-bit field is a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= FMT_RGBA8888;
      cfg_q.width  <= SIDE_RESET;
      cfg_q.height <= SIDE_RESET;
      cfg_q.pitch  <= SIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORMAT: cfg_q.fmt    <= cfg_wdata_i[2:0];
        CFG_WIDTH:  cfg_q.width  <= cfg_wdata_i;
        CFG_HEIGHT: cfg_q.height <= cfg_wdata_i;
        CFG_PITCH:  cfg_q.pitch  <= cfg_wdata_i;
      endcase
    end
  end

  // Front end: classify, bound-check, pack and compute the address.
  fmtpx_front u_front (
    .cfg_i        (cfg_q),
    .req_type_i   (req_type_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .cmd_o        (front_cmd)
  );

  // Command queue decouples acceptance from execution.
  fmtpx_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .pop_i  (cmd_pop),
    .data_o (back_cmd),
    .full_o (full),
    .empty_o(cmd_empty),
    .count_o()
  );

  // Back end: drive the store, sweep fills, unpack reads.
  fmtpx_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (back_cmd),
    .cmd_valid_i(~cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_free_i (out_free),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  assign out_free = QCNT_W'(QUEUE_DEPTH) - out_cnt;

  // Result queue: holds finished transactions while the receiver stalls.
  fmtpx_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .pop_i  (pop),
    .data_o (out_res),
    .full_o (),
    .empty_o(empty),
    .count_o(out_cnt)
  );

  assign red_out_o   = out_res.r;
  assign green_out_o = out_res.g;
  assign blue_out_o  = out_res.b;
  assign alpha_out_o = out_res.a;
  assign ok_o        = out_res.ok;

endmodule

// ===== src/fmtpx_ram.sv =====
module fmtpx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== src/fmtpx_fifo.sv =====
module fmtpx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/fmtpx_front.sv =====
module fmtpx_front
  import fmtpx_pkg::*;
(
  input  cfg_t       cfg_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [8:0] rect_width_i,
  input  logic [8:0] rect_height_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  output cmd_t       cmd_o
);

  logic [SUM_W-1:0] row_base;
  logic [SUM_W-1:0] pix_sum;
  logic [9:0]       x_end_raw, y_end_raw;
  logic [8:0]       col_end, row_end;
  logic             in_bounds, rect_empty;
  pack_t            pk;

  assign row_base  = SUM_W'(pos_y_i) * SUM_W'(cfg_i.pitch);
  assign pix_sum   = row_base + SUM_W'(pos_x_i);
  assign in_bounds = ({1'b0, pos_x_i} < cfg_i.width) && ({1'b0, pos_y_i} < cfg_i.height);
  assign pk        = pack_pixel(cfg_i.fmt, red_in_i, green_in_i, blue_in_i, alpha_in_i);

  // Clip the rectangle at the content edge.
  assign x_end_raw = 10'(pos_x_i) + 10'(rect_width_i);
  assign y_end_raw = 10'(pos_y_i) + 10'(rect_height_i);
  assign col_end   = (x_end_raw > 10'(cfg_i.width)) ? cfg_i.width : x_end_raw[8:0];
  assign row_end   = (y_end_raw > 10'(cfg_i.height)) ? cfg_i.height : y_end_raw[8:0];
  assign rect_empty = (col_end <= {1'b0, pos_x_i}) || (row_end <= {1'b0, pos_y_i});

  always_comb begin
    cmd_o.op      = OP_REPLY;
    cmd_o.ok      = 1'b0;
    cmd_o.base    = pix_sum;
    cmd_o.col     = pos_x_i;
    cmd_o.row     = pos_y_i;
    cmd_o.col_end = col_end;
    cmd_o.row_end = row_end;
    cmd_o.word    = pk.word;
    unique case (req_type_i)
      REQ_READ: begin
        if (in_bounds && pk.valid) begin
          cmd_o.op = OP_READ;
        end
      end
      REQ_WRITE: begin
        if (in_bounds && pk.valid) begin
          cmd_o.op = OP_WRITE;
        end
      end
      REQ_FILL: begin
        cmd_o.ok   = 1'b1;
        cmd_o.base = row_base;
        if (pk.valid && !rect_empty) begin
          cmd_o.op = OP_FILL;
        end
      end
      default: begin
        cmd_o.op = OP_REPLY;
      end
    endcase
  end

endmodule

// ===== src/fmtpx_back.sv =====
module fmtpx_back
  import fmtpx_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic [QCNT_W-1:0] res_free_i,
  output logic              res_push_o,
  output res_t              res_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [8:0]        fill_col_q, fill_col_d, fill_row_q, fill_row_d;
  logic [7:0]        col_start_q, col_start_d;
  logic [8:0]        col_end_q, col_end_d, row_end_q, row_end_d;
  logic [SUM_W-1:0]  row_base_q, row_base_d, fill_sum;
  logic [WORD_W-1:0] word_q, word_d;
  logic              resp_valid_q, resp_valid_d;
  logic              resp_read_q, resp_read_d;
  logic              resp_ok_q, resp_ok_d;
  logic              room, last_col, last_row;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  rgba_t             pix;

  // A result slot must stay free for the one still in the response stage.
  assign room     = res_free_i > QCNT_W'(resp_valid_q);
  assign fill_sum = row_base_q + SUM_W'(fill_col_q);
  assign last_col = (fill_col_q + 9'd1) == col_end_q;
  assign last_row = (fill_row_q + 9'd1) == row_end_q;

  always_comb begin
    state_d      = state_q;
    fill_col_d   = fill_col_q;
    fill_row_d   = fill_row_q;
    col_start_d  = col_start_q;
    col_end_d    = col_end_q;
    row_end_d    = row_end_q;
    row_base_d   = row_base_q;
    word_d       = word_q;
    resp_valid_d = 1'b0;
    resp_read_d  = 1'b0;
    resp_ok_d    = 1'b0;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = AW'(cmd_i.base);
    mem_wdata    = cmd_i.word;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_READ: begin
              resp_valid_d = 1'b1;
              resp_read_d  = 1'b1;
              resp_ok_d    = 1'b1;
            end
            OP_WRITE: begin
              mem_we       = 1'b1;
              resp_valid_d = 1'b1;
              resp_ok_d    = 1'b1;
            end
            OP_FILL: begin
              state_d     = ST_FILL;
              fill_col_d  = {1'b0, cmd_i.col};
              fill_row_d  = {1'b0, cmd_i.row};
              col_start_d = cmd_i.col;
              col_end_d   = cmd_i.col_end;
              row_end_d   = cmd_i.row_end;
              row_base_d  = cmd_i.base;
              word_d      = cmd_i.word;
            end
            OP_REPLY: begin
              resp_valid_d = 1'b1;
              resp_ok_d    = cmd_i.ok;
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_addr  = AW'(fill_sum);
        mem_wdata = word_q;
        if (last_col && last_row) begin
          // Last pixel: write it and answer once the result queue has room.
          if (room) begin
            mem_we       = 1'b1;
            resp_valid_d = 1'b1;
            resp_ok_d    = 1'b1;
            fill_col_d   = '0;
            fill_row_d   = '0;
            state_d      = ST_IDLE;
          end
        end else begin
          mem_we = 1'b1;
          if (last_col) begin
            fill_col_d = {1'b0, col_start_q};
            fill_row_d = fill_row_q + 9'd1;
            row_base_d = row_base_q + SUM_W'(cfg_i.pitch);
          end else begin
            fill_col_d = fill_col_q + 9'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_col_q   <= '0;
      fill_row_q   <= '0;
      resp_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_col_q   <= fill_col_d;
      fill_row_q   <= fill_row_d;
      resp_valid_q <= resp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_start_q <= col_start_d;
    col_end_q   <= col_end_d;
    row_end_q   <= row_end_d;
    row_base_q  <= row_base_d;
    word_q      <= word_d;
    resp_read_q <= resp_read_d;
    resp_ok_q   <= resp_ok_d;
  end

  fmtpx_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign pix        = unpack_pixel(cfg_i.fmt, mem_rdata);
  assign res_push_o = resp_valid_q;

  always_comb begin
    res_o    = '0;
    res_o.ok = resp_ok_q;
    if (resp_read_q) begin
      res_o.r = pix.r;
      res_o.g = pix.g;
      res_o.b = pix.b;
      res_o.a = pix.a;
    end
  end

endmodule
